>>> rtl/mctt_pkg.sv
// Shared types and constants for the multi-channel timeout table.
// Holds the channel count, item codes and the input and result beat structs.
// No dependencies.
package mctt_pkg;

    localparam int CHANNELS    = 8;
    localparam int MAX_RESULTS = 8;
    localparam int IDX_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HITS_W      = $clog2(MAX_RESULTS + 1);

    localparam logic [31:0] EXPIRY_LIMIT = 32'h7FFF_FFFF;
    localparam logic [31:0] DELAY_NOW    = 32'hFFFF_FFFF;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_ARM  = 2'd1;
    localparam logic [1:0] MODE_SCAN = 2'd2;
    localparam logic [1:0] MODE_RSVD = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  channel;
        logic [31:0] delay_ticks;
    } in_item_t;

    typedef struct packed {
        logic        fired;
        logic [2:0]  fired_channel;
        logic [31:0] tick_now;
        logic        last;
    } out_item_t;

endpackage

>>> rtl/multi_channel_timeout_table.sv
// Multi-channel timeout table: tick counter, deadline memory and scan sequencer.
// Depends on mctt_pkg.
//
// Usage: the input channel (s_valid/s_ready/s_data) takes one beat per item:
// tick, arm or scan. The result channel (m_valid/m_ready/m_data) returns the
// result beats of each item in order; the final beat of an item has last set.
// Tick, arm and unused codes give one beat, registered in the cycle after
// acceptance, and the next item may be accepted in the same cycle that beat
// is taken, so such items run at one per cycle while m_ready stays high.
// A scan reads the deadline memory one channel per cycle while the output
// register is free (one synchronous read port with registered read data).
// Each fired channel is held in a pending register until the next hit or
// the flush, so the last flag can be set on the final one; at most
// MAX_RESULTS channels are reported per scan.
// While a scan runs, s_ready is low. A stall on m_ready holds the output
// register and freezes the scan; s_ready stays low while a beat waits.
// Reset clears the tick counter, all armed flags and the output valid flag;
// deadlines need no clearing since an unarmed channel never uses its entry.
module multi_channel_timeout_table
    import mctt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(CHANNELS - 1);
    localparam logic [HITS_W-1:0] HITS_MAX = HITS_W'(MAX_RESULTS - 1);

    state_t                state_reg, state_next;
    logic [31:0]           tick_reg, tick_next;
    logic [CHANNELS-1:0]   armed_reg, armed_next;
    logic [IDX_W-1:0]      scan_idx_reg, scan_idx_next;
    logic [HITS_W-1:0]     hits_reg, hits_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]      pend_ch_reg, pend_ch_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_data_reg;

    logic [31:0]           dl_mem [CHANNELS];
    logic [31:0]           ram_q_reg;
    logic [IDX_W-1:0]      rd_addr;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [31:0]           mem_wdata;

    logic                  out_free;
    logic                  accept;
    logic                  hit;
    logic                  scan_end;
    logic                  push;
    out_item_t             push_data;
    logic [31:0]           age;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign age      = tick_reg - ram_q_reg;
    assign hit      = armed_reg[scan_idx_reg] && (age < EXPIRY_LIMIT);
    assign scan_end = (scan_idx_reg == LAST_IDX) || (hit && (hits_reg == HITS_MAX));

    always_comb begin
        state_next      = state_reg;
        tick_next       = tick_reg;
        armed_next      = armed_reg;
        scan_idx_next   = scan_idx_reg;
        hits_next       = hits_reg;
        pend_valid_next = pend_valid_reg;
        pend_ch_next    = pend_ch_reg;
        push            = 1'b0;
        push_data       = '0;
        rd_addr         = '0;
        mem_we          = 1'b0;
        mem_waddr       = IDX_W'(s_data.channel);
        mem_wdata       = (s_data.delay_ticks == DELAY_NOW) ? tick_reg
                                                            : tick_reg + s_data.delay_ticks;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    push           = 1'b1;
                    push_data.last = 1'b1;
                    priority if (s_data.mode == MODE_TICK) begin
                        tick_next = tick_reg + 32'd1;
                    end else if (s_data.mode == MODE_ARM) begin
                        if (32'(s_data.channel) < CHANNELS) begin
                            mem_we                = 1'b1;
                            armed_next[mem_waddr] = (s_data.delay_ticks != '0);
                        end
                    end else if (s_data.mode == MODE_SCAN) begin
                        // memory already reads channel zero; first compare next cycle
                        push            = 1'b0;
                        state_next      = ST_SCAN;
                        scan_idx_next   = '0;
                        hits_next       = '0;
                        pend_valid_next = 1'b0;
                    end else begin
                        tick_next = tick_reg;
                    end
                end
            end
            ST_SCAN: begin
                rd_addr = scan_idx_reg;
                if (out_free) begin
                    if (hit) begin
                        armed_next[scan_idx_reg] = 1'b0;
                        hits_next                = hits_reg + HITS_W'(1);
                        pend_valid_next          = 1'b1;
                        pend_ch_next             = scan_idx_reg;
                        // a newer hit means the held one is not final
                        if (pend_valid_reg) begin
                            push                    = 1'b1;
                            push_data.fired         = 1'b1;
                            push_data.fired_channel = 3'(pend_ch_reg);
                            push_data.last          = 1'b0;
                        end
                    end
                    if (scan_end) begin
                        state_next = ST_FLUSH;
                    end else begin
                        scan_idx_next = scan_idx_reg + IDX_W'(1);
                        rd_addr       = scan_idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    push                    = 1'b1;
                    push_data.fired         = pend_valid_reg;
                    push_data.fired_channel = pend_valid_reg ? 3'(pend_ch_reg) : 3'd0;
                    push_data.last          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        push_data.tick_now = tick_next;
        m_valid_next = push ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    // deadline memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            dl_mem[mem_waddr] <= mem_wdata;
        end
        ram_q_reg <= dl_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            tick_reg       <= '0;
            armed_reg      <= '0;
            scan_idx_reg   <= '0;
            hits_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            armed_reg      <= armed_next;
            scan_idx_reg   <= scan_idx_next;
            hits_reg       <= hits_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_ch_reg <= pend_ch_next;
        if (push) begin
            m_data_reg <= push_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> rtl/mctt_checker.sv
// Port-level checks for the multi-channel timeout table, bound to the top level.
// Depends on mctt_pkg and multi_channel_timeout_table.
module mctt_checker
    import mctt_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // reset empties the result register
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat valid after reset");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

    a_idle_is_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.fired |-> m_data.last && (m_data.fired_channel == 3'd0))
        else $error("non-fired beat not final or carries a channel");

    // beats of one scan all report the same tick
    a_scan_tick_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last |=> $stable(m_data.tick_now))
        else $error("tick changed inside a scan");

    // no new item while a scan still owes beats
    a_no_accept_mid_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> !(s_valid && s_ready))
        else $error("item accepted before scan finished");

endmodule

bind multi_channel_timeout_table mctt_checker u_mctt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Testbench for multi_channel_timeout_table: directed and random tick, arm, scan and unused beats.
// A scoreboard class predicts every result beat and checks them in order.
// Depends on mctt_pkg and the multi_channel_timeout_table RTL.
module testbench;
    import mctt_pkg::*;

    class timeout_scoreboard;
        logic [31:0] tick_count;
        logic [31:0] deadline [CHANNELS];
        logic        armed [CHANNELS];
        out_item_t   pending_beats[$];
        int          errors;
        int          items_seen;
        int          beats_seen;
        int          expiries_seen;

        function new();
            tick_count = '0;
            for (int i = 0; i < CHANNELS; i++) begin
                deadline[i] = '0;
                armed[i]    = 1'b0;
            end
            errors        = 0;
            items_seen    = 0;
            beats_seen    = 0;
            expiries_seen = 0;
        endfunction

        // Advance the table by one accepted beat and queue the beats it causes.
        function void record_item(in_item_t it);
            out_item_t   beat;
            logic [31:0] age;
            int          hits;
            hits = 0;
            items_seen++;
            case (it.mode)
                MODE_TICK: tick_count = tick_count + 32'd1;
                MODE_ARM: begin
                    deadline[it.channel] = (it.delay_ticks == DELAY_NOW) ?
                        tick_count : tick_count + it.delay_ticks;
                    armed[it.channel] = (it.delay_ticks != '0);
                end
                MODE_SCAN: begin
                    for (int i = 0; i < CHANNELS && hits < MAX_RESULTS; i++) begin
                        age = tick_count - deadline[i];
                        if (armed[i] && age < EXPIRY_LIMIT) begin
                            armed[i]           = 1'b0;
                            beat.fired         = 1'b1;
                            beat.fired_channel = 3'(i);
                            beat.tick_now      = tick_count;
                            beat.last          = 1'b0;
                            pending_beats.push_back(beat);
                            hits++;
                        end
                    end
                end
                default: ;
            endcase
            if (hits > 0) begin
                // mark the final expiry of this scan
                beat = pending_beats.pop_back();
                beat.last = 1'b1;
                pending_beats.push_back(beat);
            end else begin
                beat.fired         = 1'b0;
                beat.fired_channel = '0;
                beat.tick_now      = tick_count;
                beat.last          = 1'b1;
                pending_beats.push_back(beat);
            end
        endfunction

        function void report(string field, longint unsigned want, longint unsigned got);
            $error("result field %s: expected 0x%0h, got 0x%0h", field, want, got);
            errors++;
        endfunction

        function void compare_beat(out_item_t got);
            out_item_t want;
            beats_seen++;
            if (pending_beats.size() == 0) begin
                $error("result beat with nothing pending: 0x%0h", got);
                errors++;
            end else begin
                want = pending_beats.pop_front();
                if (want.fired) expiries_seen++;
                if (got.fired !== want.fired) report("fired", want.fired, got.fired);
                if (got.fired_channel !== want.fired_channel)
                    report("fired_channel", want.fired_channel, got.fired_channel);
                if (got.tick_now !== want.tick_now)
                    report("tick_now", want.tick_now, got.tick_now);
                if (got.last !== want.last) report("last", want.last, got.last);
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    int src_idle_pct;
    int dst_idle_pct;

    timeout_scoreboard sb;

    multi_channel_timeout_table u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk    = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;
        src_idle_pct = 12;
        dst_idle_pct = 63;
        sb = new();
    end

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // Note the input beat before checking: a result never leaves in its item's cycle.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.record_item(s_data);
            if (m_valid && m_ready) sb.compare_beat(m_data);
        end
    end

    function automatic in_item_t make_item(logic [1:0] mode, logic [2:0] ch, logic [31:0] dly);
        in_item_t it;
        it.mode        = mode;
        it.channel     = ch;
        it.delay_ticks = dly;
        return it;
    endfunction

    function automatic logic [31:0] pick_delay();
        case ($urandom_range(9))
            0:       return '0;
            1:       return DELAY_NOW;
            2, 3, 4: return 32'($urandom_range(1, 12));
            5:       return 32'h7FFF_FFFC + 32'($urandom_range(0, 7));
            6:       return 32'hFFFF_FFF0 + 32'($urandom_range(0, 14));
            default: return $urandom;
        endcase
    endfunction

    function automatic in_item_t pick_item();
        int r;
        r = $urandom_range(99);
        if (r < 35) return make_item(MODE_TICK, 3'($urandom), $urandom);
        if (r < 65) return make_item(MODE_ARM, 3'($urandom), pick_delay());
        if (r < 95) return make_item(MODE_SCAN, 3'($urandom), $urandom);
        return make_item(MODE_RSVD, 3'($urandom), $urandom);
    endfunction

    task automatic send_item(in_item_t it);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic arm_all_and_scan();
        for (int ch = 0; ch < CHANNELS; ch++) begin
            send_item(make_item(MODE_ARM, 3'(ch),
                ($urandom_range(3) == 0) ? pick_delay() : DELAY_NOW));
        end
        send_item(make_item(MODE_SCAN, 3'($urandom), $urandom));
    endtask

    task automatic send_random(int count);
        int n;
        n = 0;
        while (n < count) begin
            // every so often load the whole table so a scan returns a long burst
            if ($urandom_range(99) < 4) begin
                arm_all_and_scan();
                n += CHANNELS + 1;
            end else begin
                send_item(pick_item());
                n++;
            end
        end
    endtask

    initial begin
        #(5_000_000);
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty scan, disarm, expiry boundary on both sides, unused code
        send_item(make_item(MODE_TICK, 3'd0, 32'd0));
        send_item(make_item(MODE_SCAN, 3'd0, 32'd0));
        send_item(make_item(MODE_ARM, 3'd0, 32'd0));
        send_item(make_item(MODE_ARM, 3'd1, DELAY_NOW));
        send_item(make_item(MODE_ARM, 3'd2, 32'h8000_0002));
        send_item(make_item(MODE_ARM, 3'd3, 32'h8000_0001));
        send_item(make_item(MODE_ARM, 3'd4, 32'h7FFF_FFFF));
        send_item(make_item(MODE_ARM, 3'd5, 32'd2));
        send_item(make_item(MODE_RSVD, 3'd7, 32'hFFFF_FFFF));
        send_item(make_item(MODE_SCAN, 3'd7, 32'hFFFF_FFFF));
        send_item(make_item(MODE_TICK, 3'd0, 32'd0));
        send_item(make_item(MODE_TICK, 3'd0, 32'd0));
        send_item(make_item(MODE_SCAN, 3'd0, 32'd0));
        send_item(make_item(MODE_ARM, 3'd7, 32'd1));
        send_item(make_item(MODE_ARM, 3'd7, 32'd0));
        send_item(make_item(MODE_TICK, 3'd0, 32'd0));
        send_item(make_item(MODE_SCAN, 3'd0, 32'd0));
        for (int ch = 0; ch < CHANNELS; ch++) begin
            send_item(make_item(MODE_ARM, 3'(ch), DELAY_NOW));
        end
        send_item(make_item(MODE_SCAN, 3'd0, 32'd0));

        send_random(145);
        src_idle_pct = 63;
        dst_idle_pct = 12;
        send_random(145);
        src_idle_pct = 0;
        dst_idle_pct = 0;
        send_random(144);

        @(negedge aclk);
        s_valid <= 1'b0;

        while (sb.pending_beats.size() > 0) @(posedge aclk);
        repeat (CHANNELS + 4) @(posedge aclk);

        $display("testbench: %0d input beats driven, %0d result beats checked",
            sb.items_seen, sb.beats_seen);
        $display("testbench: %0d channel expiries reported, %0d mismatches",
            sb.expiries_seen, sb.errors);
        if (sb.errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
